// ===== design/annexb_pkg.sv =====
// Shared types and constants of the Annex B NAL unit splitter.
package annexb_pkg;

  localparam int NCELL  = 8;
  localparam int MAXR   = 5;
  localparam int CNT_W  = $clog2(NCELL + 1);
  localparam int NRES_W = $clog2(MAXR + 1);

  localparam logic [7:0] BYTE_ZERO = 8'h00;
  localparam logic [7:0] BYTE_ONE  = 8'h01;
  localparam logic [1:0] ZERO_MAX  = 2'd3;
  localparam logic [1:0] CODE_ZEROS = 2'd2;

  typedef struct packed {
    logic [7:0]         nal_byte;
    logic               first;
    logic               last;
    logic               keyframe;
    logic signed [63:0] timestamp;
  } nal_res_t;

  typedef nal_res_t [MAXR-1:0] res_vec_t;

  typedef struct packed {
    logic shift;
    logic wr;
  } cell_ctl_t;

endpackage

// ===== design/annexb_parser.sv =====
// Start code parser that turns one packet byte into up to five result beats.
module annexb_parser (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        accept,
  input  logic [7:0]                  packet_byte,
  input  logic                        packet_last,
  input  logic                        packet_keyframe,
  input  logic signed [63:0]          timestamp,
  output annexb_pkg::res_vec_t        res,
  output logic [annexb_pkg::NRES_W-1:0] nres
);

  localparam int NRES_W = annexb_pkg::NRES_W;

  logic       inside_r, inside_nxt;
  logic [1:0] pz_r, pz_nxt;
  logic [7:0] hb_r, hb_nxt;
  logic       hv_r, hv_nxt;
  logic       hf_r, hf_nxt;
  logic       at_start_r, at_start_nxt;
  logic [1:0] sz_r, sz_nxt;

  logic       e1, l1, e3, lastz, tail_first;
  logic [2:0] z;
  logic [7:0] tail_byte;
  logic       is_zero, is_code;

  assign is_zero = (packet_byte == annexb_pkg::BYTE_ZERO);
  assign is_code = (packet_byte == annexb_pkg::BYTE_ONE) && (pz_r >= annexb_pkg::CODE_ZEROS);

  always_comb begin
    e1 = 1'b0;
    l1 = 1'b0;
    e3 = 1'b0;
    z = 3'd0;
    lastz = 1'b0;
    tail_byte = packet_byte;
    tail_first = 1'b0;
    if (!inside_r) begin
      e1 = 1'b0;
    end else if (at_start_r) begin
      e3 = packet_last;
      tail_first = 1'b1;
    end else if (is_zero) begin
      lastz = 1'b1;
      if (pz_r != annexb_pkg::ZERO_MAX) begin
        e1 = packet_last & hv_r;
        z = packet_last ? ({1'b0, pz_r} + 3'd1) : 3'd0;
      end else begin
        e1 = hv_r;
        z = packet_last ? 3'd4 : 3'd0;
      end
    end else if (is_code) begin
      e1 = hv_r;
      l1 = 1'b1;
    end else begin
      e1 = hv_r;
      z = {1'b0, pz_r};
      e3 = packet_last;
    end
  end

  always_comb begin
    logic [2:0] k;
    for (int j = 0; j < annexb_pkg::MAXR; j++) begin
      k = 3'(j) - {2'b00, e1};
      res[j].keyframe = packet_keyframe;
      res[j].timestamp = timestamp;
      if (e1 && (j == 0)) begin
        res[j].nal_byte = hb_r;
        res[j].first = hf_r;
        res[j].last = l1;
      end else if (k < z) begin
        res[j].nal_byte = annexb_pkg::BYTE_ZERO;
        res[j].first = 1'b0;
        res[j].last = lastz && (k == (z - 3'd1));
      end else begin
        res[j].nal_byte = tail_byte;
        res[j].first = tail_first;
        res[j].last = 1'b1;
      end
    end
    nres = NRES_W'(z) + NRES_W'(e1) + NRES_W'(e3);
  end

  always_comb begin
    inside_nxt = inside_r;
    pz_nxt = pz_r;
    hb_nxt = hb_r;
    hv_nxt = hv_r;
    hf_nxt = hf_r;
    at_start_nxt = at_start_r;
    sz_nxt = sz_r;
    if (!inside_r) begin
      if (is_zero) begin
        if (sz_r != annexb_pkg::ZERO_MAX) begin
          sz_nxt = sz_r + 2'd1;
        end
      end else if ((packet_byte == annexb_pkg::BYTE_ONE) && (sz_r >= annexb_pkg::CODE_ZEROS)) begin
        inside_nxt = 1'b1;
        at_start_nxt = 1'b1;
        pz_nxt = 2'd0;
        hv_nxt = 1'b0;
        hf_nxt = 1'b0;
        sz_nxt = 2'd0;
      end else begin
        sz_nxt = 2'd0;
      end
    end else if (at_start_r) begin
      hb_nxt = packet_byte;
      hv_nxt = 1'b1;
      hf_nxt = 1'b1;
      at_start_nxt = 1'b0;
      pz_nxt = 2'd0;
    end else if (is_zero) begin
      if (pz_r != annexb_pkg::ZERO_MAX) begin
        pz_nxt = pz_r + 2'd1;
      end else begin
        hb_nxt = annexb_pkg::BYTE_ZERO;
        hv_nxt = 1'b1;
        hf_nxt = 1'b0;
      end
    end else if (is_code) begin
      hv_nxt = 1'b0;
      hf_nxt = 1'b0;
      pz_nxt = 2'd0;
      at_start_nxt = 1'b1;
    end else begin
      pz_nxt = 2'd0;
      hb_nxt = packet_byte;
      hv_nxt = 1'b1;
      hf_nxt = 1'b0;
    end
    if (packet_last) begin
      inside_nxt = 1'b0;
      pz_nxt = 2'd0;
      hb_nxt = 8'd0;
      hv_nxt = 1'b0;
      hf_nxt = 1'b0;
      at_start_nxt = 1'b0;
      sz_nxt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inside_r <= 1'b0;
      pz_r <= 2'd0;
      hb_r <= 8'd0;
      hv_r <= 1'b0;
      hf_r <= 1'b0;
      at_start_r <= 1'b0;
      sz_r <= 2'd0;
    end else if (accept) begin
      inside_r <= inside_nxt;
      pz_r <= pz_nxt;
      hb_r <= hb_nxt;
      hv_r <= hv_nxt;
      hf_r <= hf_nxt;
      at_start_r <= at_start_nxt;
      sz_r <= sz_nxt;
    end
  end

  a_held_inside: assert property (@(posedge clk) disable iff (!rst_n)
    (inside_r && !at_start_r) |-> hv_r)
    else $error("no held byte inside a unit");

endmodule

// ===== design/annexb_cell.sv =====
// One cell of the result queue: holds one beat and takes its neighbor's on a shift.
module annexb_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  annexb_pkg::cell_ctl_t ctl,
  input  annexb_pkg::nal_res_t  wr_data,
  input  logic                 nb_valid,
  input  annexb_pkg::nal_res_t  nb_data,
  output logic                 valid,
  output annexb_pkg::nal_res_t  data
);

  logic                 valid_r, valid_nxt;
  annexb_pkg::nal_res_t data_r, data_nxt;

  always_comb begin
    valid_nxt = valid_r;
    data_nxt = data_r;
    if (ctl.wr) begin
      valid_nxt = 1'b1;
      data_nxt = wr_data;
    end else if (ctl.shift) begin
      valid_nxt = nb_valid;
      data_nxt = nb_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign valid = valid_r;
  assign data = data_r;

endmodule

// ===== design/annexb_nal_splitter.sv =====
// Top level of the Annex B NAL unit splitter.
// Takes one packet byte per cycle and emits NAL unit payload beats with start codes removed,
// marking the first and last beat of each unit; each beat carries the keyframe flag and
// timestamp of the input beat that produced it. An input beat produces zero to five result
// beats, which enter a queue of eight cells; the head cell drives the result port directly
// from a register. The input stalls while more than three result beats are queued, so the
// block sustains one input beat per cycle as long as the results drain at least as fast as
// they are produced; the longer flush bursts at packet end can stall the input.
module annexb_nal_splitter (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         in_packet_byte,
  input  logic               in_packet_last,
  input  logic               in_packet_keyframe,
  input  logic signed [63:0] in_timestamp,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_nal_byte,
  output logic               out_nal_first,
  output logic               out_nal_last,
  output logic               out_keyframe_out,
  output logic signed [63:0] out_timestamp_out
);

  localparam int NCELL = annexb_pkg::NCELL;
  localparam int CNT_W = annexb_pkg::CNT_W;

  logic                                acc, pop;
  logic [CNT_W-1:0]                    cnt_r, cnt_nxt, base, nw;
  logic [annexb_pkg::NRES_W-1:0]       nres;
  annexb_pkg::res_vec_t                res;
  logic [NCELL-1:0]                    cell_valid;
  annexb_pkg::nal_res_t                cell_data [NCELL];

  assign in_stall = (cnt_r > CNT_W'(NCELL - annexb_pkg::MAXR));
  assign acc = in_valid && !in_stall;
  assign pop = cell_valid[0] && !out_stall;
  assign base = cnt_r - CNT_W'(pop);
  assign nw = acc ? CNT_W'(nres) : '0;
  assign cnt_nxt = base + nw;

  annexb_parser u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .accept          (acc),
    .packet_byte     (in_packet_byte),
    .packet_last     (in_packet_last),
    .packet_keyframe (in_packet_keyframe),
    .timestamp       (in_timestamp),
    .res             (res),
    .nres            (nres)
  );

  for (genvar gi = 0; gi < NCELL; gi++) begin : g_cell
    annexb_pkg::cell_ctl_t ctl;
    annexb_pkg::nal_res_t  wr_data;
    logic                  nb_valid;
    annexb_pkg::nal_res_t  nb_data;
    logic [CNT_W-1:0]      off;

    assign off = CNT_W'(gi) - base;
    assign ctl.shift = pop;
    assign ctl.wr = (CNT_W'(gi) >= base) && (CNT_W'(gi) < (base + nw));
    assign wr_data = res[off[annexb_pkg::NRES_W-1:0]];

    if (gi == NCELL - 1) begin : g_end
      assign nb_valid = 1'b0;
      assign nb_data = '0;
    end else begin : g_mid
      assign nb_valid = cell_valid[gi+1];
      assign nb_data = cell_data[gi+1];
    end

    annexb_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .wr_data  (wr_data),
      .nb_valid (nb_valid),
      .nb_data  (nb_data),
      .valid    (cell_valid[gi]),
      .data     (cell_data[gi])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign out_valid = cell_valid[0];
  assign out_nal_byte = cell_data[0].nal_byte;
  assign out_nal_first = cell_data[0].first;
  assign out_nal_last = cell_data[0].last;
  assign out_keyframe_out = cell_data[0].keyframe;
  assign out_timestamp_out = cell_data[0].timestamp;

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(NCELL))
    else $error("queue count out of range");

  a_cnt_valid: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == int'(cnt_r))
    else $error("queue count does not match occupied cells");

  a_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_valid + NCELL'(1)) & cell_valid) == '0)
    else $error("occupied cells are not contiguous from the head");

  a_nres_max: assert property (@(posedge clk) disable iff (!rst_n)
    acc |-> (int'(nres) <= annexb_pkg::MAXR))
    else $error("too many result beats for one input beat");

endmodule

// ===== verif/annexb_nal_splitter_test.sv =====
// Self-checking testbench for the Annex B NAL unit splitter: directed and random packets.
class nal_scoreboard;
  annexb_pkg::nal_res_t expected_q[$];
  int errors;
  int beats_in;
  int beats_out;
  int units_out;

  bit       in_unit;
  bit [1:0] unit_zeros;
  bit [7:0] held;
  bit       held_ok;
  bit       held_first;
  bit       unit_start;
  bit [1:0] hunt_zeros;

  function new();
    clear_state();
  endfunction

  function void clear_state();
    in_unit    = 1'b0;
    unit_zeros = '0;
    held       = '0;
    held_ok    = 1'b0;
    held_first = 1'b0;
    unit_start = 1'b0;
    hunt_zeros = '0;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function void push(logic [7:0] b, bit first, bit last, bit kf, logic signed [63:0] ts);
    annexb_pkg::nal_res_t r;
    r.nal_byte  = b;
    r.first     = first;
    r.last      = last;
    r.keyframe  = kf;
    r.timestamp = ts;
    expected_q.push_back(r);
  endfunction

  function void flush_held(bit last, bit kf, logic signed [63:0] ts);
    if (held_ok) begin
      push(held, held_first, last, kf, ts);
      held_ok    = 1'b0;
      held_first = 1'b0;
    end
  endfunction

  function void note_input(logic [7:0] b, bit last_in, bit kf, logic signed [63:0] ts);
    beats_in++;
    if (!in_unit) begin
      if (b == annexb_pkg::BYTE_ZERO) begin
        if (hunt_zeros < annexb_pkg::ZERO_MAX) hunt_zeros++;
      end else if (b == annexb_pkg::BYTE_ONE && hunt_zeros >= annexb_pkg::CODE_ZEROS) begin
        in_unit    = 1'b1;
        unit_start = 1'b1;
        unit_zeros = '0;
        held_ok    = 1'b0;
        held_first = 1'b0;
        hunt_zeros = '0;
      end else begin
        hunt_zeros = '0;
      end
    end else if (unit_start) begin
      held       = b;
      held_ok    = 1'b1;
      held_first = 1'b1;
      unit_start = 1'b0;
      unit_zeros = '0;
    end else if (b == annexb_pkg::BYTE_ZERO) begin
      if (unit_zeros < annexb_pkg::ZERO_MAX) begin
        unit_zeros++;
      end else begin
        flush_held(1'b0, kf, ts);
        held       = annexb_pkg::BYTE_ZERO;
        held_ok    = 1'b1;
        held_first = 1'b0;
      end
    end else if (b == annexb_pkg::BYTE_ONE && unit_zeros >= annexb_pkg::CODE_ZEROS) begin
      flush_held(1'b1, kf, ts);
      unit_zeros = '0;
      unit_start = 1'b1;
    end else begin
      flush_held(1'b0, kf, ts);
      repeat (unit_zeros) push(annexb_pkg::BYTE_ZERO, 1'b0, 1'b0, kf, ts);
      unit_zeros = '0;
      held       = b;
      held_ok    = 1'b1;
      held_first = 1'b0;
    end

    if (last_in) begin
      if (in_unit && !unit_start) begin
        if (unit_zeros == 0) begin
          flush_held(1'b1, kf, ts);
        end else begin
          flush_held(1'b0, kf, ts);
          for (int k = 1; k <= unit_zeros; k++)
            push(annexb_pkg::BYTE_ZERO, 1'b0, k == unit_zeros, kf, ts);
        end
      end
      clear_state();
    end
  endfunction

  function void check_result(annexb_pkg::nal_res_t got);
    annexb_pkg::nal_res_t want;
    beats_out++;
    if (got.first) units_out++;
    if (expected_q.size() == 0) begin
      $error("Unexpected result beat: nal_byte %02h first %0b last %0b", got.nal_byte,
             got.first, got.last);
      errors++;
      return;
    end
    want = expected_q.pop_front();
    if (got.nal_byte !== want.nal_byte) begin
      $error("nal_byte: expected %02h, got %02h", want.nal_byte, got.nal_byte);
      errors++;
    end
    if (got.first !== want.first) begin
      $error("nal_first: expected %0b, got %0b", want.first, got.first);
      errors++;
    end
    if (got.last !== want.last) begin
      $error("nal_last: expected %0b, got %0b", want.last, got.last);
      errors++;
    end
    if (got.keyframe !== want.keyframe) begin
      $error("keyframe_out: expected %0b, got %0b", want.keyframe, got.keyframe);
      errors++;
    end
    if (got.timestamp !== want.timestamp) begin
      $error("timestamp_out: expected %0d, got %0d", want.timestamp, got.timestamp);
      errors++;
    end
  endfunction
endclass

module annexb_nal_splitter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 200;

  typedef struct {
    logic [7:0]         data;
    bit                 last;
    bit                 kf;
    logic signed [63:0] ts;
  } in_beat_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         in_packet_byte = '0;
  logic               in_packet_last = 1'b0;
  logic               in_packet_keyframe = 1'b0;
  logic signed [63:0] in_timestamp = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         out_nal_byte;
  logic               out_nal_first;
  logic               out_nal_last;
  logic               out_keyframe_out;
  logic signed [63:0] out_timestamp_out;

  nal_scoreboard sb = new();
  in_beat_t      stim_q[$];
  int            packets_sent = 0;
  int            burst_left = 0;
  bit            hold_req = 1'b0;
  int            hold_cnt = 0;
  int            stall_pct = 0;
  int            pattern_cnt = 0;
  int            quiet_cycles = 0;

  annexb_nal_splitter u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_packet_byte     (in_packet_byte),
    .in_packet_last     (in_packet_last),
    .in_packet_keyframe (in_packet_keyframe),
    .in_timestamp       (in_timestamp),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_nal_byte       (out_nal_byte),
    .out_nal_first      (out_nal_first),
    .out_nal_last       (out_nal_last),
    .out_keyframe_out   (out_keyframe_out),
    .out_timestamp_out  (out_timestamp_out)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (hold_cnt != 0) begin
      hold_cnt--;
      out_stall <= 1'b1;
    end else if (hold_req) begin
      hold_req = 1'b0;
      hold_cnt = HOLD_CYCLES - 1;
      out_stall <= 1'b1;
    end else begin
      if (pattern_cnt == 0) begin
        pattern_cnt = 64;
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 20;
          2: stall_pct = 50;
          default: stall_pct = 80;
        endcase
      end
      pattern_cnt--;
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    annexb_pkg::nal_res_t got;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      got.nal_byte  = out_nal_byte;
      got.first     = out_nal_first;
      got.last      = out_nal_last;
      got.keyframe  = out_keyframe_out;
      got.timestamp = out_timestamp_out;
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timed out with %0d result beats still expected.", sb.pending());
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [7:0] rnd_byte();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return annexb_pkg::BYTE_ZERO;
      4: return annexb_pkg::BYTE_ONE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic add_beat(logic [7:0] d, bit kf, logic signed [63:0] ts);
    in_beat_t b;
    b.data = d;
    b.last = 1'b0;
    b.kf   = kf;
    b.ts   = ts;
    stim_q.push_back(b);
  endtask

  task automatic add_bytes(logic [7:0] bytes[$], bit kf, logic signed [63:0] ts);
    foreach (bytes[i]) add_beat(bytes[i], kf, ts);
  endtask

  task automatic end_packet();
    stim_q[stim_q.size() - 1].last = 1'b1;
    packets_sent++;
  endtask

  task automatic gen_packet();
    bit                 kf;
    logic signed [63:0] ts;
    int                 units;
    kf = 1'($urandom_range(0, 1));
    ts = {$urandom, $urandom};
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) add_beat(rnd_byte(), kf, ts);
    end else begin
      repeat ($urandom_range(0, 2)) add_beat(8'($urandom_range(1, 255)), kf, ts);
      units = $urandom_range(1, 3);
      for (int u = 0; u < units; u++) begin
        repeat (($urandom_range(0, 7) == 0) ? $urandom_range(4, 6) : $urandom_range(2, 3))
          add_beat(annexb_pkg::BYTE_ZERO, kf, ts);
        add_beat(annexb_pkg::BYTE_ONE, kf, ts);
        repeat ($urandom_range(0, 7)) begin
          if ($urandom_range(0, 15) == 0) begin
            kf = ~kf;
            ts = {$urandom, $urandom};
          end
          add_beat(rnd_byte(), kf, ts);
        end
      end
    end
    end_packet();
  endtask

  task automatic gen_random(int n_beats);
    int start_size;
    start_size = stim_q.size();
    while (stim_q.size() - start_size < n_beats) gen_packet();
  endtask

  task automatic run_queue();
    in_beat_t b;
    int       gap;
    while (stim_q.size() != 0) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left = $urandom_range(1, 32);
      end
      b = stim_q.pop_front();
      in_valid           <= 1'b1;
      in_packet_byte     <= b.data;
      in_packet_last     <= b.last;
      in_packet_keyframe <= b.kf;
      in_timestamp       <= b.ts;
      do @(posedge clk); while (in_stall);
      sb.note_input(b.data, b.last, b.kf, b.ts);
      burst_left--;
      @(negedge clk);
    end
    in_valid <= 1'b0;
  endtask

  task automatic drain_results();
    do @(negedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    add_bytes('{8'h00, 8'h00, 8'h01, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01, 8'h80, 8'h00,
                8'h00}, 1'b1, 64'sh8000_0000_0000_0000);
    end_packet();
    add_bytes('{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h05}, 1'b1,
              64'sh7FFF_FFFF_FFFF_FFFF);
    add_bytes('{8'h00, 8'h00, 8'h01}, 1'b0, 64'sh0123_4567_89AB_CDEF);
    end_packet();
    add_bytes('{8'h00, 8'h01, 8'h7F}, 1'b0, -64'sd1);
    end_packet();
    run_queue();
    drain_results();

    hold_req = 1'b1;
    gen_random(150);
    run_queue();
    drain_results();
    gen_random(150);
    run_queue();

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Ran %0d packets as %0d input beats, with start codes of every length.",
             packets_sent, sb.beats_in);
    $display("Checked %0d result beats in %0d units under random stalls and a long hold.",
             sb.beats_out, sb.units_out);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
